// File: sv/bcq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bcq_pkg;

  // store geometry
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int IDX_W       = $clog2(STORE_DEPTH + 1);

  // opcodes
  localparam logic [7:0] OPC_F = 8'h46;
  localparam logic [7:0] OPC_D = 8'h44;
  localparam logic [7:0] OPC_M = 8'h4D;
  localparam logic [7:0] OPC_S = 8'h73;

  // operation codes
  localparam logic [1:0] OP_RECEIVE  = 2'd0;
  localparam logic [1:0] OP_READ     = 2'd1;
  localparam logic [1:0] OP_INVAL    = 2'd2;
  localparam logic [1:0] OP_VALIDATE = 2'd3;

  // control codes carried after an M opcode
  localparam logic [15:0] CC_RESET_A    = 16'd1;
  localparam logic [15:0] CC_START      = 16'd2;
  localparam logic [15:0] CC_COMMIT     = 16'd3;
  localparam logic [15:0] CC_END        = 16'd4;
  localparam logic [15:0] CC_RESET_B    = 16'd7;
  localparam logic [15:0] CC_COND_RESET = 16'd8;

  // reply payloads
  localparam logic [15:0] RPL_COMMIT = 16'd5;
  localparam logic [15:0] RPL_OK     = 16'd1;
  localparam logic [15:0] RPL_RESET  = 16'd0;

  typedef struct packed {
    logic [1:0]         operation;
    logic [7:0]         msg_opcode;
    logic signed [15:0] msg_payload;
    logic signed [15:0] distance;
  } cmd_t;

  typedef struct packed {
    logic               reply_valid;
    logic [7:0]         reply_opcode;
    logic signed [15:0] reply_payload;
    logic               read_valid;
    logic [7:0]         read_opcode;
    logic signed [15:0] read_payload;
    logic [7:0]         next_opcode;
    logic               overflow;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic scan_rd;
    logic scan_chk;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic scan_go;
    logic scan_stop;
  } sts_t;

endpackage

`default_nettype wire

// File: sv/batched_command_queue_rollback.sv
`timescale 1ns / 1ps
`default_nettype none

// Batched command queue with rollback.
// Input channel: a command beat (operation, opcode, payload, distance) on
// 'command' is taken at a rising edge where start is high and busy is low.
// Output channel: one result beat per command, shown on 'result' for exactly
// one cycle while done is high; the receiver has to take it then.
// Sequence: the accepting edge moves the controller into EXEC, then SETTLE,
// then OUT, in which the result is shown. An invalidate with a nonzero head
// walks the store backward from the head between EXEC and SETTLE, with one
// store read state and one check state per entry, up to the store depth.
// A new command may be accepted in the cycle that shows the previous result,
// not before it. The SETTLE state is there for the single-port store read
// that follows each update to fetch the new head.
// Reset (rst, synchronous, active high) empties the queue: head, tail and
// both counts go to zero, batching off, store marked valid. Store contents
// are not cleared; entries are defined once written.
module batched_command_queue_rollback (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire bcq_pkg::cmd_t command,
  output logic               busy,
  output logic               done,
  output bcq_pkg::res_t      result
);
  import bcq_pkg::*;

  ctl_t ctl;
  sts_t sts;

  bcq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  bcq_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .command (command),
    .ctl     (ctl),
    .sts     (sts),
    .result  (result)
  );

endmodule

`default_nettype wire

// File: sv/bcq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bcq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire bcq_pkg::sts_t sts,
  output bcq_pkg::ctl_t      ctl,
  output logic               busy,
  output logic               done
);
  import bcq_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_EXEC     = 6'b000010,
    ST_SCAN_RD  = 6'b000100,
    ST_SCAN_CHK = 6'b001000,
    ST_SETTLE   = 6'b010000,
    ST_OUT      = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   open_slot;

  // a new beat may enter while idle or while the result is shown
  assign open_slot = (state == ST_IDLE) || (state == ST_OUT);
  assign busy      = !open_slot;
  assign done      = (state == ST_OUT);

  assign ctl.latch    = open_slot && start;
  assign ctl.exec     = (state == ST_EXEC);
  assign ctl.scan_rd  = (state == ST_SCAN_RD);
  assign ctl.scan_chk = (state == ST_SCAN_CHK);

  // sequencing
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE, ST_OUT: begin
        state_next = start ? ST_EXEC : ST_IDLE;
      end
      ST_EXEC: begin
        state_next = sts.scan_go ? ST_SCAN_RD : ST_SETTLE;
      end
      ST_SCAN_RD: begin
        state_next = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        state_next = sts.scan_stop ? ST_SETTLE : ST_SCAN_RD;
      end
      ST_SETTLE: begin
        state_next = ST_OUT;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/bcq_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module bcq_dpath (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire bcq_pkg::cmd_t command,
  input  wire bcq_pkg::ctl_t ctl,
  output bcq_pkg::sts_t      sts,
  output bcq_pkg::res_t      result
);
  import bcq_pkg::*;

  // command store
  logic [23:0] mem [STORE_DEPTH];
  logic [23:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [23:0] wr_data;
  logic        wr_en;

  // latched beat
  cmd_t cmd_q;

  // queue state
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  tail;
  logic [IDX_W-1:0]  committed;
  logic [IDX_W-1:0]  pending;
  logic              in_batch;
  logic              store_valid;
  logic [ADDR_W-1:0] scan;

  // result registers
  logic        rv;
  logic [7:0]  rop;
  logic [15:0] rpl;
  logic        dv;
  logic [7:0]  dop;
  logic [15:0] dpl;
  logic        ovf;

  logic        is_ctrl;
  logic        has_room;
  logic        can_pop;
  logic [7:0]  rd_opc;
  logic        rd_is_f;
  logic [15:0] roll_pl;
  logic [IDX_W-1:0] head_dec;

  assign is_ctrl  = (cmd_q.msg_opcode == OPC_M);
  assign has_room = (tail != IDX_W'(STORE_DEPTH));
  assign can_pop  = store_valid && (committed != '0) && (head < IDX_W'(STORE_DEPTH));
  assign rd_opc   = rd_data[7:0];
  assign rd_is_f  = (rd_opc == OPC_F);
  assign roll_pl  = rd_data[23:8] - $unsigned(cmd_q.distance);
  assign head_dec = head - IDX_W'(1);

  // status to the controller
  assign sts.scan_go   = (cmd_q.operation == OP_INVAL) && (head != '0);
  assign sts.scan_stop = rd_is_f || (rd_opc == OPC_D) || (scan == '0);

  // store port selection
  assign rd_addr = ctl.scan_rd ? scan : head[ADDR_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = tail[ADDR_W-1:0];
    wr_data = {$unsigned(cmd_q.msg_payload), cmd_q.msg_opcode};
    if (ctl.exec && (cmd_q.operation == OP_RECEIVE) && !is_ctrl && has_room) begin
      wr_en = 1'b1;
    end else if (ctl.scan_chk && rd_is_f) begin
      wr_en   = 1'b1;
      wr_addr = head_dec[ADDR_W-1:0];
      wr_data = {roll_pl, OPC_F};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // beat capture and result registers
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_q <= command;
      rv    <= 1'b0;
      rop   <= '0;
      rpl   <= '0;
      dv    <= 1'b0;
      dop   <= '0;
      dpl   <= '0;
      ovf   <= 1'b0;
    end else if (ctl.exec) begin
      case (cmd_q.operation)
        OP_RECEIVE: begin
          if (is_ctrl) begin
            if ($unsigned(cmd_q.msg_payload) == CC_COMMIT) begin
              rv  <= 1'b1;
              rop <= OPC_M;
              rpl <= RPL_COMMIT;
            end else if ($unsigned(cmd_q.msg_payload) == CC_COND_RESET) begin
              rv  <= 1'b1;
              rop <= OPC_S;
              rpl <= store_valid ? RPL_OK : RPL_RESET;
            end
          end else if (!has_room) begin
            ovf <= 1'b1;
          end
        end
        OP_READ: begin
          if (can_pop) begin
            dv  <= 1'b1;
            dop <= rd_data[7:0];
            dpl <= rd_data[23:8];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // queue state update
  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      tail        <= '0;
      committed   <= '0;
      pending     <= '0;
      in_batch    <= 1'b0;
      store_valid <= 1'b1;
      scan        <= '0;
    end else if (ctl.exec) begin
      case (cmd_q.operation)
        OP_RECEIVE: begin
          if (is_ctrl) begin
            case ($unsigned(cmd_q.msg_payload))
              CC_START: begin
                in_batch <= 1'b1;
                pending  <= '0;
              end
              CC_COMMIT: begin
                in_batch  <= 1'b1;
                committed <= committed + pending;
                pending   <= '0;
              end
              CC_END: begin
                in_batch  <= 1'b0;
                committed <= committed + pending;
                pending   <= '0;
              end
              CC_COND_RESET: begin
                if (!store_valid) begin
                  head        <= '0;
                  tail        <= '0;
                  committed   <= '0;
                  pending     <= '0;
                  in_batch    <= 1'b0;
                  store_valid <= 1'b1;
                end
              end
              CC_RESET_A, CC_RESET_B: begin
                head        <= '0;
                tail        <= '0;
                committed   <= '0;
                pending     <= '0;
                in_batch    <= 1'b0;
                store_valid <= 1'b1;
              end
              default: begin
              end
            endcase
          end else if (has_room) begin
            tail <= tail + IDX_W'(1);
            if (in_batch) begin
              pending <= pending + IDX_W'(1);
            end else begin
              committed <= committed + IDX_W'(1);
            end
          end
        end
        OP_READ: begin
          if (can_pop) begin
            head      <= head + IDX_W'(1);
            committed <= committed - IDX_W'(1);
          end
        end
        OP_INVAL: begin
          store_valid <= 1'b0;
          scan        <= head_dec[ADDR_W-1:0];
        end
        default: begin
          store_valid <= 1'b1;
        end
      endcase
    end else if (ctl.scan_chk) begin
      // backward search: forward entry found, roll back in front of the head
      if (rd_is_f) begin
        head      <= head_dec;
        committed <= committed + IDX_W'(1);
      end else if (!sts.scan_stop) begin
        scan <= scan - ADDR_W'(1);
      end
    end
  end

  // result beat
  always_comb begin
    result.reply_valid   = rv;
    result.reply_opcode  = rop;
    result.reply_payload = $signed(rpl);
    result.read_valid    = dv;
    result.read_opcode   = dop;
    result.read_payload  = $signed(dpl);
    result.next_opcode   = can_pop ? rd_opc : 8'h00;
    result.overflow      = ovf;
  end

endmodule

`default_nettype wire

// File: sv/bcq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bcq_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done,
  input wire bcq_pkg::res_t result
);
  import bcq_pkg::*;

  // a shown result leaves room for the next beat
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // an accepted beat makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // one result per beat, never two in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // a reply, a read and an overflow never come together
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    done |-> ($countones({result.reply_valid, result.read_valid, result.overflow}) <= 1))
    else $error("result carries more than one kind");

endmodule

bind batched_command_queue_rollback bcq_checker u_bcq_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .result  (result)
);

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import bcq_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_ITEMS  = 1000;
  // longest invalidate walk plus some margin
  localparam int SETTLE_CYCLES = 3 + 2 * STORE_DEPTH + 16;

  // mirror of the command queue and the results it is owed
  class cmd_queue_checker;
    logic [23:0] mirror_store [STORE_DEPTH];
    int unsigned head;
    int unsigned tail;
    int unsigned committed;
    int unsigned pending;
    bit          in_batch;
    bit          store_ok;
    res_t        due_results [$];
    int          errors;

    function new();
      clear_queue();
      errors = 0;
    endfunction

    function void clear_queue();
      head      = 0;
      tail      = 0;
      committed = 0;
      pending   = 0;
      in_batch  = 1'b0;
      store_ok  = 1'b1;
    endfunction

    // update the mirror for one command and work out its result
    function res_t apply_command(cmd_t c);
      res_t        r;
      int unsigned i;
      bit          found;
      logic [15:0] np;
      r = '0;
      found = 1'b0;
      case (c.operation)
        OP_RECEIVE: begin
          if (c.msg_opcode == OPC_M) begin
            case (c.msg_payload)
              CC_START: begin
                in_batch = 1'b1;
                pending  = 0;
              end
              CC_COMMIT: begin
                in_batch = 1'b1;
                committed += pending;
                pending = 0;
                r.reply_valid   = 1'b1;
                r.reply_opcode  = OPC_M;
                r.reply_payload = RPL_COMMIT;
              end
              CC_END: begin
                in_batch = 1'b0;
                committed += pending;
                pending = 0;
              end
              CC_COND_RESET: begin
                r.reply_valid  = 1'b1;
                r.reply_opcode = OPC_S;
                if (store_ok) begin
                  r.reply_payload = RPL_OK;
                end else begin
                  r.reply_payload = RPL_RESET;
                  clear_queue();
                end
              end
              CC_RESET_A, CC_RESET_B: clear_queue();
              default: ;
            endcase
          end else if (tail < STORE_DEPTH) begin
            mirror_store[tail] = {c.msg_payload, c.msg_opcode};
            tail++;
            if (in_batch) pending++;
            else committed++;
          end else begin
            r.overflow = 1'b1;
          end
        end
        OP_READ: begin
          if (store_ok && committed != 0 && head < STORE_DEPTH) begin
            r.read_valid   = 1'b1;
            r.read_opcode  = mirror_store[head][7:0];
            r.read_payload = mirror_store[head][23:8];
            head++;
            committed--;
          end
        end
        OP_INVAL: begin
          store_ok = 1'b0;
          i = (head > STORE_DEPTH) ? STORE_DEPTH : head;
          // walk back to the nearest forward or stop marker
          while (i > 0) begin
            i--;
            if (mirror_store[i][7:0] == OPC_F) begin
              found = 1'b1;
              break;
            end
            if (mirror_store[i][7:0] == OPC_D) break;
          end
          if (found && head > 0 && head <= STORE_DEPTH) begin
            np = mirror_store[i][23:8] - c.distance;
            head--;
            committed++;
            mirror_store[head] = {np, OPC_F};
          end
        end
        default: store_ok = 1'b1;
      endcase
      if (store_ok && committed != 0 && head < STORE_DEPTH)
        r.next_opcode = mirror_store[head][7:0];
      return r;
    endfunction

    function void note_command(cmd_t c);
      due_results.push_back(apply_command(c));
    endfunction

    function void mismatch(string field, logic [15:0] want, logic [15:0] got);
      $display("%0t mismatch %s: expected %h, actual %h", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.reply_valid !== want.reply_valid)
        mismatch("reply_valid", want.reply_valid, got.reply_valid);
      if (got.reply_opcode !== want.reply_opcode)
        mismatch("reply_opcode", want.reply_opcode, got.reply_opcode);
      if (got.reply_payload !== want.reply_payload)
        mismatch("reply_payload", want.reply_payload, got.reply_payload);
      if (got.read_valid !== want.read_valid)
        mismatch("read_valid", want.read_valid, got.read_valid);
      if (got.read_opcode !== want.read_opcode)
        mismatch("read_opcode", want.read_opcode, got.read_opcode);
      if (got.read_payload !== want.read_payload)
        mismatch("read_payload", want.read_payload, got.read_payload);
      if (got.next_opcode !== want.next_opcode)
        mismatch("next_opcode", want.next_opcode, got.next_opcode);
      if (got.overflow !== want.overflow)
        mismatch("overflow", want.overflow, got.overflow);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start;
  cmd_t command;
  logic busy;
  logic done;
  res_t result;

  cmd_queue_checker sb;
  int idle_cycles;
  int sent;
  bit burst;

  always #4 clk = ~clk;

  batched_command_queue_rollback dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .command(command),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // result check and watchdog
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic cmd_t make_cmd(logic [1:0] op, logic [7:0] opc, logic [15:0] pl,
                                    logic [15:0] travel);
    cmd_t c;
    c.operation   = op;
    c.msg_opcode  = opc;
    c.msg_payload = pl;
    c.distance    = travel;
    return c;
  endfunction

  function automatic logic [15:0] rand_distance();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  // data beat, biased towards forward and stop markers
  function automatic cmd_t random_data();
    logic [7:0] opc;
    case ($urandom_range(0, 3))
      0: opc = OPC_F;
      1: opc = OPC_D;
      default: opc = 8'($urandom_range(0, 255));
    endcase
    if (opc == OPC_M) opc = OPC_F;
    return make_cmd(OP_RECEIVE, opc, 16'($urandom), 16'($urandom));
  endfunction

  function automatic cmd_t control(logic [15:0] code);
    return make_cmd(OP_RECEIVE, OPC_M, code, 16'($urandom));
  endfunction

  function automatic cmd_t plain(logic [1:0] op);
    return make_cmd(op, 8'($urandom), 16'($urandom), rand_distance());
  endfunction

  // anything at all, with small control codes now and then
  function automatic cmd_t noise();
    cmd_t c;
    c = plain(2'($urandom_range(0, 3)));
    if ($urandom_range(0, 3) == 0) begin
      c.msg_opcode  = OPC_M;
      c.msg_payload = 16'($urandom_range(0, 9));
    end
    return c;
  endfunction

  // one command beat; start stays high across back-to-back beats
  task automatic send(cmd_t c);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    command <= c;
    do @(posedge clk); while (busy);
    sb.note_command(c);
    sent++;
  endtask

  // hold off until every owed result is back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.due_results.size() != 0);
  endtask

  task automatic run_segment();
    int kind;
    kind  = $urandom_range(0, 99);
    burst = ($urandom_range(0, 3) == 0);
    if (kind < 30) begin
      repeat ($urandom_range(1, 8)) send(random_data());
    end else if (kind < 50) begin
      repeat ($urandom_range(1, 6)) send(plain(OP_READ));
    end else if (kind < 65) begin
      // batch with optional commit, closed or discarded
      send(control(CC_START));
      repeat ($urandom_range(0, 5)) send(random_data());
      if ($urandom_range(0, 1)) begin
        send(control(CC_COMMIT));
        repeat ($urandom_range(0, 3)) send(random_data());
      end
      if ($urandom_range(0, 3) == 0) send(control(CC_START));
      else send(control(CC_END));
    end else if (kind < 73) begin
      send(plain(OP_INVAL));
      case ($urandom_range(0, 2))
        0: send(plain(OP_VALIDATE));
        1: send(control(CC_COND_RESET));
        default: ;
      endcase
    end else if (kind < 78) begin
      send(control(CC_COND_RESET));
    end else if (kind < 84) begin
      send(control($urandom_range(0, 1) ? CC_RESET_A : CC_RESET_B));
    end else if (kind < 85) begin
      repeat (STORE_DEPTH + 4) send(random_data());
    end else if (kind < 95) begin
      repeat ($urandom_range(1, 4)) send(noise());
    end else if (kind < 98) begin
      send(plain(OP_VALIDATE));
    end else begin
      drain();
    end
  endtask

  initial begin
    sb      = new();
    rst     = 1'b1;
    start   = 1'b0;
    command = '0;
    sent    = 0;
    burst   = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, pops, rollback and the control codes
    send(make_cmd(OP_RECEIVE, OPC_F, 16'd100, 16'h0000));
    send(make_cmd(OP_RECEIVE, 8'h00, 16'h8000, 16'hffff));
    send(make_cmd(OP_RECEIVE, 8'hff, 16'h7fff, 16'h0000));
    send(make_cmd(OP_READ, 8'h00, 16'h0000, 16'h0000));
    send(make_cmd(OP_READ, 8'hff, 16'hffff, 16'hffff));
    // rollback finds the forward marker, payload wraps
    send(make_cmd(OP_INVAL, 8'h00, 16'h0000, 16'h8000));
    // read while invalid
    send(make_cmd(OP_READ, 8'h00, 16'h0000, 16'h0000));
    send(make_cmd(OP_VALIDATE, 8'h00, 16'h0000, 16'h0000));
    send(make_cmd(OP_READ, 8'h00, 16'h0000, 16'h0000));
    send(make_cmd(OP_READ, 8'h00, 16'h0000, 16'h0000));
    // read with nothing committed
    send(make_cmd(OP_READ, 8'h00, 16'h0000, 16'h0000));
    send(make_cmd(OP_RECEIVE, OPC_D, 16'd7, 16'h0000));
    send(make_cmd(OP_READ, 8'h00, 16'h0000, 16'h0000));
    // rollback stopped by a stop marker
    send(make_cmd(OP_INVAL, 8'h00, 16'h0000, 16'h7fff));
    send(control(CC_COND_RESET));
    send(control(CC_COND_RESET));
    // batch: commit, then a discarded pending beat, then close
    send(control(CC_START));
    send(make_cmd(OP_RECEIVE, 8'h41, 16'd1, 16'h0000));
    send(control(CC_COMMIT));
    send(make_cmd(OP_RECEIVE, OPC_D, 16'd2, 16'h0000));
    send(control(CC_START));
    send(make_cmd(OP_RECEIVE, OPC_F, 16'hffff, 16'h0000));
    send(control(CC_END));
    send(control(CC_RESET_A));
    send(control(CC_RESET_B));
    send(control(16'hffff));
    // rollback from the store start
    send(make_cmd(OP_INVAL, 8'h00, 16'h0000, 16'h1234));
    send(make_cmd(OP_VALIDATE, 8'h00, 16'h0000, 16'h0000));
    drain();

    // random sequences
    sent = 0;
    while (sent < RANDOM_ITEMS) run_segment();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
